[sv/cis_pkg.sv]
`default_nettype none
package cis_pkg;

	// Default sizes of the weight table.
	localparam int unsigned DEF_MAX_ENTRIES = 256;
	localparam int unsigned DEF_WEIGHT_BITS = 16;

	// Fixed field widths of the item channels.
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned FRAC_W   = 32;

	// Configuration port.
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned ENTRY_CNT_W = 9;
	localparam logic [ENTRY_CNT_W-1:0] ENTRY_CNT_RESET = 9'd256;

	// Register indexes, taken from the word part of the byte address.
	localparam logic [CFG_ADDR_W-3:0] REG_ENTRY_COUNT = 1'b0;

	// Action codes of an input item.
	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DRAW = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TIE  = 2'd2;

endpackage
`default_nettype wire

[sv/cis_in_if.sv]
`default_nettype none
interface cis_in_if;
	import cis_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  entry_index;
	logic [WEIGHT_W-1:0] weight;
	logic [FRAC_W-1:0]   uniform;

	modport source (output valid, action, entry_index, weight, uniform, input ready);
	modport sink (input valid, action, entry_index, weight, uniform, output ready);

endinterface
`default_nettype wire

[sv/cis_out_if.sv]
`default_nettype none
interface cis_out_if;
	import cis_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] sample_index;
	logic               all_zero;

	modport source (output valid, sample_index, all_zero, input ready);
	modport sink (input valid, sample_index, all_zero, output ready);

endinterface
`default_nettype wire

[sv/cis_table.sv]
`default_nettype none
module cis_table #(
	parameter int unsigned MAX_ENTRIES = cis_pkg::DEF_MAX_ENTRIES,
	parameter int unsigned WEIGHT_BITS = cis_pkg::DEF_WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
	input  logic [WEIGHT_BITS-1:0]         wr_data,
	input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
	output logic [WEIGHT_BITS-1:0]         rd_data
);
	import cis_pkg::*;

	logic [WEIGHT_BITS-1:0] mem_q [MAX_ENTRIES];

	// Single write port for load items.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, one entry per cycle during a scan.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

[sv/cis_mul.sv]
`default_nettype none
module cis_mul #(
	parameter int unsigned OP_W = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [OP_W-1:0]            operand,
	input  logic [cis_pkg::FRAC_W-1:0] frac,
	output logic                       done,
	output logic [OP_W-1:0]            product
);
	import cis_pkg::*;

	localparam int unsigned STEP_W = $clog2(FRAC_W);

	logic [OP_W-1:0]   op_q;
	logic [FRAC_W-1:0] frac_q;
	logic [OP_W-1:0]   acc_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [OP_W:0]     sum;

	// Shift-add step: add the operand for the current fraction bit, then drop
	// the lowest bit, which belongs to the discarded part of the product.
	assign sum = {1'b0, acc_q} + (frac_q[0] ? {1'b0, op_q} : {(OP_W + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			frac_q <= '0;
			acc_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= operand;
				frac_q <= frac;
				acc_q  <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q  <= sum[OP_W:1];
				frac_q <= frac_q >> 1;
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

[sv/categorical_inverse_cdf_sampler.sv]
// A load item writes the table, and the block stays idle and ready for more items.
// A draw over n entries runs a table scan for the total or maximum, the serial
// multiplier for the threshold, and a search scan that stops at the chosen entry.
// One item is in work at a time; the result waits in an output register.
// Reset (arst_n, asynchronous) clears control state and sets entry_count to 256.
`default_nettype none
module categorical_inverse_cdf_sampler #(
	parameter int unsigned MAX_ENTRIES = cis_pkg::DEF_MAX_ENTRIES,
	parameter int unsigned WEIGHT_BITS = cis_pkg::DEF_WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cis_in_if.sink                         items,
	cis_out_if.source                      results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cis_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cis_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cis_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cis_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TOT_W = WEIGHT_BITS + IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// Configuration register.
	logic [ENTRY_CNT_W-1:0] entry_count_q;
	logic                   cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = paddr[CFG_ADDR_W-1:2] == REG_ENTRY_COUNT;
	assign prdata  = cfg_hit ? CFG_DATA_W'(entry_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_CNT_RESET;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			entry_count_q <= pwdata[ENTRY_CNT_W-1:0];
		end
	end

	// Entries used by a draw, held to the range 1 .. MAX_ENTRIES.
	logic [CNT_W-1:0] n_used;

	always_comb begin
		if (entry_count_q == '0) begin
			n_used = CNT_W'(1);
		end else if (32'(entry_count_q) > MAX_ENTRIES) begin
			n_used = CNT_W'(MAX_ENTRIES);
		end else begin
			n_used = CNT_W'(entry_count_q);
		end
	end

	// Sequencer and datapath registers.
	state_t             state_q;
	logic               tie_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   issue_q;
	logic               rv_s1;
	logic               rl_s1;
	logic [IDX_W-1:0]   ri_s1;
	logic [TOT_W-1:0]   total_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOT_W-1:0]   thr_q;
	logic [TOT_W-1:0]   run_q;
	logic [CNT_W-1:0]   seen_q;
	logic [IDX_W-1:0]   pick_q;
	logic               zero_q;
	logic               mul_start_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic               out_zero_q;

	logic                   in_acc;
	logic                   load_wr;
	logic                   issuing;
	logic [WEIGHT_BITS-1:0] rd_data;
	logic [TOT_W-1:0]       total_nx;
	logic [WEIGHT_BITS-1:0] best_nx;
	logic [CNT_W-1:0]       count_nx;
	logic [TOT_W-1:0]       run_nx;
	logic                   is_best;
	logic                   hit;
	logic                   mul_done;
	logic [TOT_W-1:0]       mul_prod;

	assign items.ready = state_q == ST_IDLE;
	assign in_acc      = items.valid && items.ready;
	assign load_wr     = in_acc && items.action == ACT_LOAD
			&& 32'(items.entry_index) < MAX_ENTRIES;
	assign issuing     = (state_q == ST_SCAN || state_q == ST_SEARCH) && issue_q < n_q;

	cis_table #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_table (
		.clk    (clk),
		.wr_en  (load_wr),
		.wr_addr(IDX_W'(items.entry_index)),
		.wr_data(WEIGHT_BITS'(items.weight)),
		.rd_addr(issue_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	cis_mul #(
		.OP_W(TOT_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.operand(tie_q ? TOT_W'(count_q) : total_q),
		.frac   (frac_q),
		.done   (mul_done),
		.product(mul_prod)
	);

	// Per-entry updates for the entry whose data has just come back.
	always_comb begin
		total_nx = total_q + TOT_W'(rd_data);
		best_nx  = best_q;
		count_nx = count_q;
		if (ri_s1 == '0 || rd_data > best_q) begin
			best_nx  = rd_data;
			count_nx = CNT_W'(1);
		end else if (rd_data == best_q) begin
			count_nx = count_q + 1'b1;
		end
		run_nx  = run_q + TOT_W'(rd_data);
		is_best = rd_data == best_q;
		if (tie_q) begin
			hit = is_best && TOT_W'(seen_q) == thr_q;
		end else begin
			hit = run_nx > thr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tie_q       <= 1'b0;
			frac_q      <= '0;
			n_q         <= '0;
			issue_q     <= '0;
			rv_s1       <= 1'b0;
			rl_s1       <= 1'b0;
			ri_s1       <= '0;
			total_q     <= '0;
			best_q      <= '0;
			count_q     <= '0;
			thr_q       <= '0;
			run_q       <= '0;
			seen_q      <= '0;
			pick_q      <= '0;
			zero_q      <= 1'b0;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_zero_q  <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;

			// Read pipeline: the address issued now returns data next cycle.
			rv_s1 <= issuing;
			ri_s1 <= issue_q[IDX_W-1:0];
			rl_s1 <= issue_q == n_q - 1'b1;
			if (issuing) begin
				issue_q <= issue_q + 1'b1;
			end

			// The output register empties when the item is taken.
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (items.action == ACT_DRAW || items.action == ACT_TIE)) begin
						tie_q   <= items.action == ACT_TIE;
						frac_q  <= items.uniform;
						n_q     <= n_used;
						issue_q <= '0;
						total_q <= '0;
						zero_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				// First pass: total weight, or the maximum and how often it occurs.
				ST_SCAN: begin
					if (rv_s1) begin
						total_q <= total_nx;
						best_q  <= best_nx;
						count_q <= count_nx;
						if (rl_s1) begin
							if (!tie_q && total_nx == '0) begin
								pick_q  <= ri_s1;
								zero_q  <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								mul_start_q <= 1'b1;
								state_q     <= ST_MUL;
							end
						end
					end
				end
				// Threshold from the serial multiplier.
				ST_MUL: begin
					if (mul_done) begin
						thr_q   <= mul_prod;
						run_q   <= '0;
						seen_q  <= '0;
						issue_q <= '0;
						state_q <= ST_SEARCH;
					end
				end
				// Second pass: stop at the entry that the threshold selects.
				ST_SEARCH: begin
					if (rv_s1) begin
						run_q <= run_nx;
						if (is_best) begin
							seen_q <= seen_q + 1'b1;
						end
						if (hit || rl_s1) begin
							pick_q  <= ri_s1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= INDEX_W'(pick_q);
						out_zero_q  <= zero_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sample_index = out_idx_q;
	assign results.all_zero     = out_zero_q;

endmodule
`default_nettype wire

[sim/tb.sv]
module tb;
	import cis_pkg::*;

	// The action code that the block ignores.
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	localparam int unsigned TABLE_DEPTH    = DEF_MAX_ENTRIES;
	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned CFG_SETTLE     = 16;
	localparam int unsigned TAIL_CYCLES    = 600;
	localparam int unsigned PHASES         = 8;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  entry_index;
		logic [WEIGHT_W-1:0] weight;
		logic [FRAC_W-1:0]   uniform;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] sample_index;
		logic               all_zero;
	} sample_t;

	typedef struct packed {
		item_t   it;
		logic    typed;
		sample_t want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	cis_in_if  items_if ();
	cis_out_if results_if ();

	categorical_inverse_cdf_sampler u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the weight table and of the entry count register.
	logic [WEIGHT_W-1:0]    weight_mem [TABLE_DEPTH];
	logic [ENTRY_CNT_W-1:0] entry_count_q;
	sample_t                pending_samples [$];
	row_t                   directed_rows [$];
	int unsigned            mismatches    = 0;
	int unsigned            src_idle_pct  = 0;
	int unsigned            snk_stall_pct = 0;
	int unsigned            idle_cycles   = 0;

	// Random phases: entry count, sender idling, receiver stalling, items.
	int unsigned phase_count [PHASES] = '{8, 0, 3, 256, 40, 511, 1, 130};
	int unsigned phase_src   [PHASES] = '{0, 51, 0, 25, 51, 0, 25, 0};
	int unsigned phase_snk   [PHASES] = '{0, 0, 51, 25, 0, 0, 25, 51};
	int unsigned phase_items [PHASES] = '{70, 35, 70, 35, 70, 25, 45, 55};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Entries that a draw scans: the register held to 1..TABLE_DEPTH.
	function automatic int unsigned used_entries();
		if (entry_count_q == 0)
			return 1;
		if (entry_count_q > TABLE_DEPTH)
			return TABLE_DEPTH;
		return entry_count_q;
	endfunction

	// Works out the sample that a draw item yields from the shadow table.
	function automatic sample_t predict_sample(input item_t it);
		int unsigned         n;
		longint unsigned     total;
		longint unsigned     run;
		longint unsigned     thr;
		longint unsigned     hits;
		longint unsigned     k;
		longint unsigned     seen;
		logic [WEIGHT_W-1:0] top;
		logic                found;
		sample_t             r;
		n = used_entries();
		r.sample_index = INDEX_W'(n - 1);
		r.all_zero = 1'b0;
		found = 1'b0;
		total = 0;
		run = 0;
		hits = 0;
		seen = 0;
		top = weight_mem[0];
		if (it.action == ACT_DRAW) begin
			for (int i = 0; i < n; i++)
				total += weight_mem[i];
			if (total == 0) begin
				r.all_zero = 1'b1;
			end else begin
				thr = (total * it.uniform) >> 32;
				for (int i = 0; i < n; i++) begin
					run += weight_mem[i];
					if (!found && run > thr) begin
						r.sample_index = INDEX_W'(i);
						found = 1'b1;
					end
				end
			end
		end else begin
			// Tie draw: pick uniformly among the entries holding the maximum.
			for (int i = 1; i < n; i++)
				if (weight_mem[i] > top)
					top = weight_mem[i];
			for (int i = 0; i < n; i++)
				if (weight_mem[i] == top)
					hits++;
			k = (hits * it.uniform) >> 32;
			for (int i = 0; i < n; i++) begin
				if (weight_mem[i] == top) begin
					if (!found && seen == k) begin
						r.sample_index = INDEX_W'(i);
						found = 1'b1;
					end
					seen++;
				end
			end
		end
		return r;
	endfunction

	function automatic row_t mk_row(input logic [ACTION_W-1:0] act, input int unsigned idx,
			input logic [WEIGHT_W-1:0] w, input logic [FRAC_W-1:0] u, input logic typed,
			input int unsigned want_idx, input logic want_zero);
		row_t r;
		r.it.action = act;
		r.it.entry_index = INDEX_W'(idx);
		r.it.weight = w;
		r.it.uniform = u;
		r.typed = typed;
		r.want.sample_index = INDEX_W'(want_idx);
		r.want.all_zero = want_zero;
		return r;
	endfunction

	// Random item: loads aim mostly at the entries in use, and weights lean
	// towards zero, full scale and tiny values so that ties and empty totals occur.
	function automatic item_t random_item(input int unsigned n);
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			it.action = ACT_LOAD;
		else if (pick < 67)
			it.action = ACT_DRAW;
		else if (pick < 94)
			it.action = ACT_TIE;
		else
			it.action = ACT_NONE;
		if ($urandom_range(3) != 0)
			it.entry_index = INDEX_W'($urandom_range(n - 1));
		else
			it.entry_index = INDEX_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 25)
			it.weight = '0;
		else if (pick < 40)
			it.weight = '1;
		else if (pick < 70)
			it.weight = WEIGHT_W'($urandom_range(3));
		else
			it.weight = WEIGHT_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)
			it.uniform = '0;
		else if (pick < 20)
			it.uniform = '1;
		else
			it.uniform = $urandom;
		return it;
	endfunction

	// Offers one item, waits for it to be taken and updates the shadow state.
	task automatic push_item(input item_t it, input logic typed, input sample_t want);
		if ($urandom_range(99) < src_idle_pct) begin
			items_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		items_if.valid       <= 1'b1;
		items_if.action      <= it.action;
		items_if.entry_index <= it.entry_index;
		items_if.weight      <= it.weight;
		items_if.uniform     <= it.uniform;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		if (it.action == ACT_LOAD)
			weight_mem[it.entry_index] = it.weight;
		else if (it.action == ACT_DRAW || it.action == ACT_TIE)
			pending_samples.push_back(typed ? want : predict_sample(it));
	endtask

	// Holds the sender back until every expected sample has arrived.
	task automatic drain_samples();
		items_if.valid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
	endtask

	// Writes the entry count once the block is idle.
	task automatic write_entry_count(input int unsigned value);
		drain_samples();
		repeat (CFG_SETTLE) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ENTRY_COUNT, 2'b00};
		pwdata  <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		entry_count_q = ENTRY_CNT_W'(value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Receiver: stalls at random according to the current phase.
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			results_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Compares each sample taken from the block with the oldest expectation.
	always @(posedge clk) begin
		sample_t got;
		sample_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			got.sample_index = results_if.sample_index;
			got.all_zero = results_if.all_zero;
			if (pending_samples.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected sample: index %0d all_zero %0d", $time,
					got.sample_index, got.all_zero);
			end else begin
				want = pending_samples.pop_front();
				if (got.sample_index != want.sample_index) begin
					mismatches++;
					$display("%0t: sample_index mismatch: expected %0d, got %0d", $time,
						want.sample_index, got.sample_index);
				end
				if (got.all_zero != want.all_zero) begin
					mismatches++;
					$display("%0t: all_zero mismatch: expected %0d, got %0d", $time,
						want.all_zero, got.all_zero);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: zero fill, directed rows, then random phases.
	initial begin
		item_t       it;
		int unsigned done;
		logic        held;
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		items_if.valid       <= 1'b0;
		items_if.action      <= '0;
		items_if.entry_index <= '0;
		items_if.weight      <= '0;
		items_if.uniform     <= '0;
		entry_count_q = ENTRY_CNT_RESET;

		// Directed rows run with the reset entry count of 256 over a zeroed table.
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h0000_0000, 1'b1, 255, 1'b1));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'h0000_0000, 1'b1, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'hFFFF_FFFF, 1'b1, 255, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 255, 16'hFFFF, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h0000_0000, 1'b1, 255, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'hFFFF_FFFF, 1'b1, 255, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 0, 16'h0001, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h0000_0000, 1'b1, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'hFFFF_FFFF, 1'b1, 255, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'h0000_0000, 1'b1, 255, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 128, 16'hFFFF, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'h0000_0000, 1'b1, 128, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'hFFFF_FFFF, 1'b1, 255, 1'b0));
		// An unused action gives no sample and leaves the table alone.
		directed_rows.push_back(mk_row(ACT_NONE, 7, 16'h1234, 32'hDEAD_BEEF, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h8000_0000, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 255, 16'h0000, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'hFFFF_FFFF, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 64, 16'h8000, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h4000_0000, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 3, 16'hAAAA, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_LOAD, 5, 16'h5555, '0, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_DRAW, 0, '0, 32'h5555_5555, 1'b0, 0, 1'b0));
		directed_rows.push_back(mk_row(ACT_TIE, 0, '0, 32'hAAAA_AAAA, 1'b0, 0, 1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is written before the first draw reads it.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			it = '0;
			it.action = ACT_LOAD;
			it.entry_index = INDEX_W'(i);
			push_item(it, 1'b0, '0);
		end

		foreach (directed_rows[r])
			push_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

		// Random phases, each with its own entry count and idling pattern;
		// halfway through each the sender waits for all outstanding samples.
		for (int p = 0; p < PHASES; p++) begin
			write_entry_count(phase_count[p]);
			src_idle_pct = phase_src[p];
			snk_stall_pct = phase_snk[p];
			done = 0;
			held = 1'b0;
			while (done < phase_items[p]) begin
				if (!held && done == phase_items[p] / 2) begin
					drain_samples();
					held = 1'b1;
				end
				it = random_item(used_entries());
				push_item(it, 1'b0, '0);
				if (it.action != ACT_NONE)
					done++;
			end
		end

		drain_samples();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
